@@ src/npcm_pkg.sv @@
// Package for the nearest palette color mapper.
// Holds the command codes, field widths and the item record passed along the cell row.
// No dependencies.
package npcm_pkg;

  localparam int ColorWidth = 8;
  localparam int IndexWidth = 8;
  localparam int CountWidth = 9;
  localparam int DistWidth  = 18;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  typedef struct packed {
    logic                  load;
    logic [IndexWidth-1:0] entry_index;
    logic [ColorWidth-1:0] red;
    logic [ColorWidth-1:0] green;
    logic [ColorWidth-1:0] blue;
    logic                  active;
    logic [IndexWidth-1:0] best_index;
    logic [DistWidth-1:0]  best_dist;
  } item_t;

endpackage

@@ src/npcm_cell.sv @@
// One compare cell of the palette row: holds one palette entry and two pipeline stages.
// The first stage forms the squared RGB distance, the second keeps the nearest entry so far.
// Depends on npcm_pkg.
module npcm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [npcm_pkg::CountWidth-1:0]       palette_count,
  input  logic                                  in_valid,
  input  npcm_pkg::item_t                       in_item,
  output logic                                  out_valid,
  output npcm_pkg::item_t                       out_item
);

  logic [npcm_pkg::ColorWidth-1:0] entry_red;
  logic [npcm_pkg::ColorWidth-1:0] entry_green;
  logic [npcm_pkg::ColorWidth-1:0] entry_blue;

  logic                            a_valid;
  npcm_pkg::item_t                 a_item;
  logic [npcm_pkg::DistWidth-1:0]  a_dist;

  logic [npcm_pkg::ColorWidth-1:0]   diff_red;
  logic [npcm_pkg::ColorWidth-1:0]   diff_green;
  logic [npcm_pkg::ColorWidth-1:0]   diff_blue;
  logic [2*npcm_pkg::ColorWidth-1:0] sq_red;
  logic [2*npcm_pkg::ColorWidth-1:0] sq_green;
  logic [2*npcm_pkg::ColorWidth-1:0] sq_blue;
  logic [npcm_pkg::DistWidth-1:0]    entry_dist;
  logic                              in_range;
  logic                              take;
  npcm_pkg::item_t                   b_item;

  always_ff @(posedge clk) begin
    if (en && in_valid && (in_item.load == npcm_pkg::CMD_LOAD) &&
        (in_item.entry_index == npcm_pkg::IndexWidth'(CELL_INDEX))) begin
      entry_red   <= in_item.red;
      entry_green <= in_item.green;
      entry_blue  <= in_item.blue;
    end
  end

  always_comb begin
    diff_red   = (entry_red > in_item.red) ? entry_red - in_item.red : in_item.red - entry_red;
    diff_green = (entry_green > in_item.green) ? entry_green - in_item.green
                                               : in_item.green - entry_green;
    diff_blue  = (entry_blue > in_item.blue) ? entry_blue - in_item.blue
                                             : in_item.blue - entry_blue;
    sq_red     = diff_red * diff_red;
    sq_green   = diff_green * diff_green;
    sq_blue    = diff_blue * diff_blue;
    entry_dist = npcm_pkg::DistWidth'(sq_red) + npcm_pkg::DistWidth'(sq_green)
               + npcm_pkg::DistWidth'(sq_blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      a_dist <= entry_dist;
    end
  end

  always_comb begin
    in_range = npcm_pkg::CountWidth'(CELL_INDEX) < palette_count;
    take     = (a_item.load == npcm_pkg::CMD_MAP) && a_item.active && in_range &&
               (a_dist < a_item.best_dist);
    b_item   = a_item;
    if (take) begin
      b_item.best_index = npcm_pkg::IndexWidth'(CELL_INDEX);
      b_item.best_dist  = a_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= b_item;
    end
  end

endmodule

@@ src/nearest_palette_color_mapper.sv @@
// Nearest palette color mapper: a row of PALETTE_DEPTH compare cells, two stages per cell.
// An accepted item passes the head register, then both stages of each cell; one item per cycle while not stalled.
// A result not taken stalls the whole row, which then holds every item in place.
// Reset clears the valid bits and palette_count; palette entries are undefined until loaded.
// Depends on npcm_pkg and npcm_cell.
module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [npcm_pkg::CountWidth-1:0]     cfg_data,
  input  logic                                valid,
  output logic                                ready,
  input  logic                                command,
  input  logic [npcm_pkg::IndexWidth-1:0]     entry_index,
  input  logic [npcm_pkg::ColorWidth-1:0]     red,
  input  logic [npcm_pkg::ColorWidth-1:0]     green,
  input  logic [npcm_pkg::ColorWidth-1:0]     blue,
  input  logic [npcm_pkg::ColorWidth-1:0]     alpha,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [npcm_pkg::IndexWidth-1:0]     palette_index
);

  logic [npcm_pkg::CountWidth-1:0] palette_count;
  logic                            en;
  logic                            head_valid;
  npcm_pkg::item_t                 head_item;
  logic                            link_valid [PALETTE_DEPTH+1];
  npcm_pkg::item_t                 link_item  [PALETTE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= '0;
    end else if (cfg_write) begin
      palette_count <= cfg_data;
    end
  end

  assign result_valid  = link_valid[PALETTE_DEPTH] &&
                         (link_item[PALETTE_DEPTH].load == npcm_pkg::CMD_MAP);
  assign palette_index = link_item[PALETTE_DEPTH].best_index;
  assign en            = !result_valid || result_ready;
  assign ready         = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (en) begin
      head_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_item.load        <= command;
      head_item.entry_index <= entry_index;
      head_item.red         <= red;
      head_item.green       <= green;
      head_item.blue        <= blue;
      head_item.active      <= (alpha != '0);
      head_item.best_index  <= '0;
      head_item.best_dist   <= '1;
    end
  end

  assign link_valid[0] = head_valid;
  assign link_item[0]  = head_item;

  for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX(j)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .palette_count(palette_count),
      .in_valid     (link_valid[j]),
      .in_item      (link_item[j]),
      .out_valid    (link_valid[j+1]),
      .out_item     (link_item[j+1])
    );
  end

endmodule

@@ src/npcm_checker.sv @@
// Port-level checks for the nearest palette color mapper, bound to the top level.
// Depends on the top level's port list and on npcm_pkg for widths.
module npcm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [npcm_pkg::IndexWidth-1:0] palette_index
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(palette_index))
    else $error("A stalled result item changed or vanished.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("A result item was shown right after reset.");

  a_stall_blocks_input: assert property (@(posedge clk)
    result_valid && !result_ready |-> !ready)
    else $error("Input was taken while the pipeline was stalled.");

  a_free_accepts: assert property (@(posedge clk)
    !result_valid |-> ready)
    else $error("Input was refused with no result item waiting.");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (
  .clk          (clk),
  .rst          (rst),
  .ready        (ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .palette_index(palette_index)
);
